FILE: hdl/lfsc_pkg.sv
// Types, codes and the control store of the line-follow steering controller.
// Used by the channel interfaces and every module of the block; no dependencies.
package lfsc_pkg;

    // Field widths
    localparam int LEVEL_W    = 10;
    localparam int DUTY_W     = 7;
    localparam int CMD_W      = 3;
    localparam int ACT_W      = 3;
    localparam int MODE_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int PAUSE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Divider: quotient never exceeds 100, so seven quotient bits
    localparam int QUO_W     = DUTY_W;
    localparam int DIV_SHIFT = QUO_W - 1;
    localparam int NUM_W     = DUTY_W + LEVEL_W;
    localparam int CNT_W     = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_DUTY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTER_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_PAUSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_PAUSE = 3'd5;

    // Actions
    localparam logic [ACT_W-1:0] ACT_STOP   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TURN_R = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TURN_L = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FWD    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BWD    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_ROT    = 3'd6;

    // Wheel modes
    localparam logic [MODE_W-1:0] MODE_BWD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LFWD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RFWD = 2'd3;

    // Turn phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PAUSE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PIVOT = 2'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_CMD,
        OP_STOP,
        OP_TURN_START,
        OP_ROT_START,
        OP_SEL_FRONT,
        OP_SEL_BACK,
        OP_BAL_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_PEND,
        OP_PAUSE_DEC,
        OP_PIVOT,
        OP_ALIGN,
        OP_EMIT
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_IDLE,
        C_PHASE_BUSY,
        C_OFF_TRACK,
        C_TURN_HERE,
        C_DRIVE_FWD,
        C_DRIVE_BWD,
        C_ROTATE,
        C_NO_DIV,
        C_DIV_MORE,
        C_PHASE_PIVOT,
        C_PAUSE_RUN,
        C_NOT_ALIGNED,
        C_OUT_BUSY
    } t_cond;

    localparam int UADDR_W = 5;
    typedef logic [UADDR_W-1:0] t_uaddr;

    // One control word: operation, jump condition, jump target
    typedef struct packed {
        t_op    op;
        t_cond  cond;
        t_uaddr target;
    } t_uword;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_idle;
        logic phase_busy;
        logic off_track;
        logic turn_here;
        logic drive_fwd;
        logic drive_bwd;
        logic rotate;
        logic no_div;
        logic div_more;
        logic phase_pivot;
        logic pause_run;
        logic not_aligned;
        logic out_busy;
    } t_flags;

    // Program addresses
    localparam t_uaddr U_WAIT     = 5'd0;
    localparam t_uaddr U_PHASE    = 5'd1;
    localparam t_uaddr U_CMD      = 5'd2;
    localparam t_uaddr U_TRACK    = 5'd3;
    localparam t_uaddr U_D_TURN   = 5'd4;
    localparam t_uaddr U_D_FWD    = 5'd5;
    localparam t_uaddr U_D_BWD    = 5'd6;
    localparam t_uaddr U_D_ROT    = 5'd7;
    localparam t_uaddr U_STOP     = 5'd8;
    localparam t_uaddr U_TSTART   = 5'd9;
    localparam t_uaddr U_RSTART   = 5'd10;
    localparam t_uaddr U_BWD      = 5'd11;
    localparam t_uaddr U_FWD      = 5'd12;
    localparam t_uaddr U_BAL      = 5'd13;
    localparam t_uaddr U_DIV      = 5'd14;
    localparam t_uaddr U_DIV_DONE = 5'd15;
    localparam t_uaddr U_TURN     = 5'd16;
    localparam t_uaddr U_PAUSE    = 5'd17;
    localparam t_uaddr U_PIVOT    = 5'd18;
    localparam t_uaddr U_CHECK    = 5'd19;
    localparam t_uaddr U_ALIGN    = 5'd20;
    // Last address: falling through wraps back to U_WAIT
    localparam t_uaddr U_EMIT     = 5'd31;

    function automatic t_uword mk_uw(input t_op op, input t_cond cond, input t_uaddr target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store
    function automatic t_uword lfsc_urom(input t_uaddr a);
        t_uword w;
        case (a)
            U_WAIT:     w = mk_uw(OP_LATCH,      C_IN_IDLE,     U_WAIT);
            U_PHASE:    w = mk_uw(OP_NOP,        C_PHASE_BUSY,  U_TURN);
            U_CMD:      w = mk_uw(OP_CMD,        C_ALWAYS,      U_TRACK);
            U_TRACK:    w = mk_uw(OP_NOP,        C_OFF_TRACK,   U_STOP);
            U_D_TURN:   w = mk_uw(OP_NOP,        C_TURN_HERE,   U_TSTART);
            U_D_FWD:    w = mk_uw(OP_NOP,        C_DRIVE_FWD,   U_FWD);
            U_D_BWD:    w = mk_uw(OP_NOP,        C_DRIVE_BWD,   U_BWD);
            U_D_ROT:    w = mk_uw(OP_NOP,        C_ROTATE,      U_RSTART);
            U_STOP:     w = mk_uw(OP_STOP,       C_ALWAYS,      U_EMIT);
            U_TSTART:   w = mk_uw(OP_TURN_START, C_ALWAYS,      U_EMIT);
            U_RSTART:   w = mk_uw(OP_ROT_START,  C_ALWAYS,      U_EMIT);
            U_BWD:      w = mk_uw(OP_SEL_BACK,   C_ALWAYS,      U_BAL);
            U_FWD:      w = mk_uw(OP_SEL_FRONT,  C_ALWAYS,      U_BAL);
            U_BAL:      w = mk_uw(OP_BAL_INIT,   C_NO_DIV,      U_EMIT);
            U_DIV:      w = mk_uw(OP_DIV_STEP,   C_DIV_MORE,    U_DIV);
            U_DIV_DONE: w = mk_uw(OP_DIV_DONE,   C_ALWAYS,      U_EMIT);
            U_TURN:     w = mk_uw(OP_PEND,       C_PHASE_PIVOT, U_CHECK);
            U_PAUSE:    w = mk_uw(OP_PAUSE_DEC,  C_PAUSE_RUN,   U_EMIT);
            U_PIVOT:    w = mk_uw(OP_PIVOT,      C_ALWAYS,      U_CHECK);
            U_CHECK:    w = mk_uw(OP_NOP,        C_NOT_ALIGNED, U_EMIT);
            U_ALIGN:    w = mk_uw(OP_ALIGN,      C_ALWAYS,      U_BAL);
            U_EMIT:     w = mk_uw(OP_EMIT,       C_OUT_BUSY,    U_EMIT);
            default:    w = mk_uw(OP_NOP,        C_ALWAYS,      U_WAIT);
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/lfsc_if.sv
// Frame and result channel interfaces (valid/ready handshake).
// Depends on lfsc_pkg for field widths.
interface lfsc_frame_if;
    import lfsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] right_level;
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] center_level;
    logic [LEVEL_W-1:0] back_right_level;
    logic [LEVEL_W-1:0] back_left_level;
    logic [LEVEL_W-1:0] link_level;
    logic               command_valid;
    logic [CMD_W-1:0]   command_bits;

    modport source (
        output valid, right_level, left_level, center_level, back_right_level,
               back_left_level, link_level, command_valid, command_bits,
        input  ready
    );
    modport sink (
        input  valid, right_level, left_level, center_level, back_right_level,
               back_left_level, link_level, command_valid, command_bits,
        output ready
    );
endinterface

interface lfsc_result_if;
    import lfsc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic [MODE_W-1:0] wheel_mode;
    logic              at_intersection;

    modport source (
        output valid, left_duty, right_duty, wheel_mode, at_intersection,
        input  ready
    );
    modport sink (
        input  valid, left_duty, right_duty, wheel_mode, at_intersection,
        output ready
    );
endinterface

FILE: hdl/lfsc_useq.sv
// Microcode sequencer: step counter, control store and jump-condition select.
// Depends on lfsc_pkg (control word, flags, program).
module lfsc_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lfsc_pkg::t_flags i_flags,
    output lfsc_pkg::t_uword o_uw
);
    import lfsc_pkg::*;

    t_uaddr r_step;
    t_uaddr n_step;
    t_uword uw;
    logic   take;

    assign uw   = lfsc_urom(r_step);
    assign o_uw = uw;

    // Select the jump condition
    always_comb begin
        case (uw.cond)
            C_ALWAYS:      take = 1'b1;
            C_IN_IDLE:     take = i_flags.in_idle;
            C_PHASE_BUSY:  take = i_flags.phase_busy;
            C_OFF_TRACK:   take = i_flags.off_track;
            C_TURN_HERE:   take = i_flags.turn_here;
            C_DRIVE_FWD:   take = i_flags.drive_fwd;
            C_DRIVE_BWD:   take = i_flags.drive_bwd;
            C_ROTATE:      take = i_flags.rotate;
            C_NO_DIV:      take = i_flags.no_div;
            C_DIV_MORE:    take = i_flags.div_more;
            C_PHASE_PIVOT: take = i_flags.phase_pivot;
            C_PAUSE_RUN:   take = i_flags.pause_run;
            C_NOT_ALIGNED: take = i_flags.not_aligned;
            C_OUT_BUSY:    take = i_flags.out_busy;
            default:       take = 1'b0;
        endcase
        // jump or advance; the last address wraps to the wait step
        n_step = take ? uw.target : r_step + t_uaddr'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= U_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // A delivered result always returns the program to the wait step
    a_emit_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_EMIT && !i_flags.out_busy) |=> (r_step == U_WAIT))
        else $error("sequencer did not return to wait after emit");

endmodule

FILE: hdl/lfsc_dpath.sv
// Steering datapath: config registers, frame latch, steering state, serial divider
// and result register, all driven by the control word. Depends on lfsc_pkg, lfsc_if.
module lfsc_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  lfsc_pkg::t_uword              i_uw,
    output lfsc_pkg::t_flags              o_flags,
    lfsc_frame_if.sink                    i_frame,
    lfsc_result_if.source                 o_result
);
    import lfsc_pkg::*;

    // Configuration
    logic [DUTY_W-1:0]  r_base_duty;
    logic [DUTY_W-1:0]  r_rotate_duty;
    logic [LEVEL_W-1:0] r_inter_level;
    logic [LEVEL_W-1:0] r_margin;
    logic [PAUSE_W-1:0] r_turn_pause;
    logic [PAUSE_W-1:0] r_rotate_pause;

    // Latched frame
    logic [LEVEL_W-1:0] r_r, r_l, r_c, r_br, r_bl, r_link;
    logic               r_cv;
    logic [CMD_W-1:0]   r_cb;

    // Steering state
    logic [ACT_W-1:0]   r_act;
    logic [MODE_W-1:0]  r_mode;
    logic [DUTY_W-1:0]  r_ld, r_rd;
    logic [PHASE_W-1:0] r_phase;
    logic [PAUSE_W-1:0] r_pause;
    logic               r_pend_v;
    logic [CMD_W-1:0]   r_pend_cmd;
    logic               r_sel_back;

    // Divider
    logic               r_side;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_den;
    logic [QUO_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;

    // Result register
    logic               r_out_valid;
    logic [DUTY_W-1:0]  r_out_ld, r_out_rd;
    logic [MODE_W-1:0]  r_out_mode;
    logic               r_out_inter;

    logic               accept;
    logic               out_busy;
    logic               emit;
    logic [DUTY_W-1:0]  base_sat, rot_sat;
    logic [LEVEL_W-1:0] sel_r, sel_l, sel_diff, front_diff, div_min, div_max;
    logic               sel_r_gt, front_r_gt, inter, is_turn;
    logic               div_ge;

    assign base_sat = (r_base_duty > DUTY_MAX) ? DUTY_MAX : r_base_duty;
    assign rot_sat  = (r_rotate_duty > DUTY_MAX) ? DUTY_MAX : r_rotate_duty;

    // Side pair for balancing: front or rear pickups
    assign sel_r      = r_sel_back ? r_br : r_r;
    assign sel_l      = r_sel_back ? r_bl : r_l;
    assign sel_r_gt   = sel_r > sel_l;
    assign sel_diff   = sel_r_gt ? sel_r - sel_l : sel_l - sel_r;
    assign div_min    = sel_r_gt ? sel_l : sel_r;
    assign div_max    = sel_r_gt ? sel_r : sel_l;
    assign front_r_gt = r_r > r_l;
    assign front_diff = front_r_gt ? r_r - r_l : r_l - r_r;
    assign inter      = r_c > r_inter_level;
    assign is_turn    = (r_act == ACT_TURN_R) || (r_act == ACT_TURN_L);
    assign div_ge     = r_num >= r_den;

    // Handshakes
    assign i_frame.ready = (i_uw.op == OP_LATCH);
    assign accept        = i_frame.valid && i_frame.ready;
    assign out_busy      = r_out_valid && !o_result.ready;
    assign emit          = (i_uw.op == OP_EMIT) && !out_busy;

    // Status toward the sequencer
    always_comb begin
        o_flags.in_idle     = !i_frame.valid;
        o_flags.phase_busy  = (r_phase != PH_IDLE);
        o_flags.off_track   = (r_link <= r_margin);
        o_flags.turn_here   = is_turn && inter;
        o_flags.drive_fwd   = (r_act == ACT_FWD) || (is_turn && !inter);
        o_flags.drive_bwd   = (r_act == ACT_BWD);
        o_flags.rotate      = (r_act == ACT_ROT);
        o_flags.no_div      = (sel_diff <= r_margin);
        o_flags.div_more    = (r_cnt != '0);
        o_flags.phase_pivot = r_phase[1];
        o_flags.pause_run   = (r_pause != '0);
        o_flags.not_aligned = (front_diff > r_margin);
        o_flags.out_busy    = out_busy;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_duty    <= 7'd50;
            r_rotate_duty  <= 7'd45;
            r_inter_level  <= 10'd310;
            r_margin       <= 10'd31;
            r_turn_pause   <= 16'd100;
            r_rotate_pause <= 16'd500;
            r_act          <= ACT_STOP;
            r_mode         <= MODE_FWD;
            r_ld           <= '0;
            r_rd           <= '0;
            r_phase        <= PH_IDLE;
            r_pause        <= '0;
            r_pend_v       <= 1'b0;
            r_pend_cmd     <= '0;
            r_sel_back     <= 1'b0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // register writes; indexes past the list are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_DUTY:    r_base_duty    <= i_cfg_data[DUTY_W-1:0];
                    CFG_ROTATE_DUTY:  r_rotate_duty  <= i_cfg_data[DUTY_W-1:0];
                    CFG_INTER_LEVEL:  r_inter_level  <= i_cfg_data[LEVEL_W-1:0];
                    CFG_MARGIN:       r_margin       <= i_cfg_data[LEVEL_W-1:0];
                    CFG_TURN_PAUSE:   r_turn_pause   <= i_cfg_data[PAUSE_W-1:0];
                    CFG_ROTATE_PAUSE: r_rotate_pause <= i_cfg_data[PAUSE_W-1:0];
                    default: ;
                endcase
            end

            // clear the result once taken
            if (r_out_valid && o_result.ready && !emit) begin
                r_out_valid <= 1'b0;
            end

            case (i_uw.op)
                OP_CMD: begin
                    // apply a new command once, else a held one
                    if (r_cv) begin
                        r_act    <= r_cb - 3'd1;
                        r_pend_v <= 1'b0;
                    end else if (r_pend_v) begin
                        r_act    <= r_pend_cmd - 3'd1;
                        r_pend_v <= 1'b0;
                    end
                end
                OP_STOP: begin
                    r_ld <= '0;
                    r_rd <= '0;
                end
                OP_TURN_START: begin
                    r_mode  <= (r_act == ACT_TURN_R) ? MODE_RFWD : MODE_LFWD;
                    r_ld    <= '0;
                    r_rd    <= '0;
                    r_phase <= PH_PAUSE;
                    r_pause <= r_turn_pause;
                end
                OP_ROT_START: begin
                    r_mode  <= MODE_LFWD;
                    r_ld    <= rot_sat;
                    r_rd    <= rot_sat;
                    r_phase <= PH_PAUSE;
                    r_pause <= r_rotate_pause;
                end
                OP_SEL_FRONT: begin
                    r_mode     <= MODE_FWD;
                    r_sel_back <= 1'b0;
                end
                OP_SEL_BACK: begin
                    r_mode     <= MODE_BWD;
                    r_sel_back <= 1'b1;
                end
                OP_BAL_INIT: begin
                    r_ld  <= base_sat;
                    r_rd  <= base_sat;
                    r_cnt <= CNT_W'(DIV_SHIFT);
                end
                OP_DIV_STEP: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                OP_DIV_DONE: begin
                    // scale down the side with the larger code
                    if (r_side) begin
                        r_rd <= r_quo;
                    end else begin
                        r_ld <= r_quo;
                    end
                end
                OP_PEND: begin
                    // hold the latest command until the maneuver ends
                    if (r_cv) begin
                        r_pend_v   <= 1'b1;
                        r_pend_cmd <= r_cb;
                    end
                end
                OP_PAUSE_DEC: begin
                    if (r_pause != '0) begin
                        r_pause <= r_pause - PAUSE_W'(1);
                    end
                end
                OP_PIVOT: begin
                    r_phase <= PH_PIVOT;
                    if (r_act == ACT_TURN_R) begin
                        r_rd <= base_sat;
                        r_ld <= '0;
                    end else if (r_act == ACT_TURN_L) begin
                        r_ld <= base_sat;
                        r_rd <= '0;
                    end
                end
                OP_ALIGN: begin
                    r_phase    <= PH_IDLE;
                    r_act      <= ACT_FWD;
                    r_mode     <= MODE_FWD;
                    r_sel_back <= 1'b0;
                end
                OP_EMIT: begin
                    if (!out_busy) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: frame latch, divider words, result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_r    <= i_frame.right_level;
            r_l    <= i_frame.left_level;
            r_c    <= i_frame.center_level;
            r_br   <= i_frame.back_right_level;
            r_bl   <= i_frame.back_left_level;
            r_link <= i_frame.link_level;
            r_cv   <= i_frame.command_valid;
            r_cb   <= i_frame.command_bits;
        end
        if (i_uw.op == OP_BAL_INIT) begin
            // base * min over max, seven restoring steps
            r_side <= sel_r_gt;
            r_num  <= {{LEVEL_W{1'b0}}, base_sat} * {{DUTY_W{1'b0}}, div_min};
            r_den  <= {1'b0, div_max, {DIV_SHIFT{1'b0}}};
            r_quo  <= '0;
        end
        if (i_uw.op == OP_DIV_STEP) begin
            if (div_ge) begin
                r_num <= r_num - r_den;
            end
            r_quo <= {r_quo[QUO_W-2:0], div_ge};
            r_den <= r_den >> 1;
        end
        if (emit) begin
            r_out_ld    <= r_ld;
            r_out_rd    <= r_rd;
            r_out_mode  <= r_mode;
            r_out_inter <= inter;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.left_duty       = r_out_ld;
    assign o_result.right_duty      = r_out_rd;
    assign o_result.wheel_mode      = r_out_mode;
    assign o_result.at_intersection = r_out_inter;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_ld <= DUTY_MAX && r_out_rd <= DUTY_MAX))
        else $error("duty above full scale");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uw.op == OP_DIV_DONE) |-> (r_quo <= DUTY_MAX))
        else $error("balance quotient out of range");

    a_phase_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |->
            (r_act == ACT_TURN_R || r_act == ACT_TURN_L || r_act == ACT_ROT))
        else $error("maneuver phase without a turn or rotate action");

endmodule

FILE: hdl/line_follow_steering_controller.sv
// Top level of the line-follow steering controller.
// Depends on lfsc_pkg, lfsc_if, lfsc_useq and lfsc_dpath.
//
//   Channel    Dir  Handshake          Word
//   i_frame    in   valid/ready        six 10-bit pickup codes, command flag, 3-bit command
//   o_result   out  valid/ready        left/right duty, wheel mode, intersection flag
//   i_cfg_*    in   write enable only  register index, 16-bit data
//
// From acceptance to result a frame follows the steps of its microcode path;
// balanced driving runs the shared restoring divider for seven iterations.
// One frame is in flight at a time; the next is accepted once the prior result
// sits in the output register, even if that result is not yet taken.
// Reset is synchronous and active low.
// A stalled output holds the sequencer at its emit step.
module line_follow_steering_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lfsc_frame_if.sink                      i_frame,
    lfsc_result_if.source                   o_result
);
    import lfsc_pkg::*;

    t_uword uw;
    t_flags flags;

    lfsc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uw    (uw)
    );

    lfsc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_uw       (uw),
        .o_flags    (flags),
        .i_frame    (i_frame),
        .o_result   (o_result)
    );

endmodule

FILE: tb/tb_line_follow_steering_controller.sv
`timescale 1ns / 1ps
// Testbench for line_follow_steering_controller: directed frames, then random driving traffic.
// Needs lfsc_pkg, the lfsc_if channel interfaces and the controller RTL.
module tb_line_follow_steering_controller;
    import lfsc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int STALL_LIMIT = 3000;
    localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;
    localparam int HOLD_MAX    = (1 << PAUSE_W) - 1;

    // Codes outside the action list; both decode to a stop
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] r_lvl;
        logic [LEVEL_W-1:0] l_lvl;
        logic [LEVEL_W-1:0] c_lvl;
        logic [LEVEL_W-1:0] br_lvl;
        logic [LEVEL_W-1:0] bl_lvl;
        logic [LEVEL_W-1:0] link_lvl;
        logic               cmd_v;
        logic [CMD_W-1:0]   cmd;
    } t_frame;

    typedef struct packed {
        logic [DUTY_W-1:0] l_duty;
        logic [DUTY_W-1:0] r_duty;
        logic [MODE_W-1:0] mode;
        logic              crossing;
    } t_drive;

    typedef struct {
        int unsigned base;
        int unsigned rot;
        int unsigned inter;
        int unsigned margin;
        int unsigned tpause;
        int unsigned rpause;
    } t_regs;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lfsc_frame_if  frame_if ();
    lfsc_result_if result_if ();

    line_follow_steering_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frame    (frame_if),
        .o_result   (result_if)
    );

    // Register copies, at their reset values
    logic [DUTY_W-1:0]  cfg_base   = 7'd50;
    logic [DUTY_W-1:0]  cfg_rot    = 7'd45;
    logic [LEVEL_W-1:0] cfg_inter  = 10'd310;
    logic [LEVEL_W-1:0] cfg_margin = 10'd31;
    logic [PAUSE_W-1:0] cfg_tpause = 16'd100;
    logic [PAUSE_W-1:0] cfg_rpause = 16'd500;

    // Steering state, at its reset values
    logic [ACT_W-1:0]   act_q    = ACT_STOP;
    logic [MODE_W-1:0]  mode_q   = MODE_FWD;
    logic [DUTY_W-1:0]  ldrv_q   = '0;
    logic [DUTY_W-1:0]  rdrv_q   = '0;
    logic [PHASE_W-1:0] phase_q  = PH_IDLE;
    logic [PAUSE_W-1:0] hold_q   = '0;
    logic [CMD_W:0]     queued_q = '0;

    t_drive expected_drive_q[$];
    int     mismatch_cnt   = 0;
    int     frames_taken   = 0;
    int     rx_hold_cycles = 0;
    bit     tx_steady      = 1'b0;
    bit     rx_steady      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

    function automatic int unsigned level_gap(input logic [LEVEL_W-1:0] a,
                                              input logic [LEVEL_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic logic [CMD_W-1:0] cmd_of(input logic [ACT_W-1:0] a);
        return a + 3'd1;
    endfunction

    // Balance the wheels: the side with the larger code drops to base * min / max
    function automatic void balance_wheels(input logic [MODE_W-1:0] mode,
                                           input logic [LEVEL_W-1:0] r,
                                           input logic [LEVEL_W-1:0] l);
        int unsigned base;
        base   = sat_duty(cfg_base);
        mode_q = mode;
        ldrv_q = DUTY_W'(base);
        rdrv_q = DUTY_W'(base);
        if (level_gap(r, l) > cfg_margin) begin
            if (r > l)
                rdrv_q = DUTY_W'((base * l) / r);
            else if (l != 0)
                ldrv_q = DUTY_W'((base * r) / l);
        end
    endfunction

    // Leave the manoeuvre once the front codes agree
    function automatic void finish_turn(input logic [LEVEL_W-1:0] r,
                                        input logic [LEVEL_W-1:0] l);
        if (level_gap(r, l) <= cfg_margin) begin
            phase_q = PH_IDLE;
            act_q   = ACT_FWD;
            balance_wheels(MODE_FWD, r, l);
        end
    endfunction

    // Advance the steering state by one frame and return the drive word it yields
    function automatic t_drive predict_steering(input t_frame f);
        logic crossing;
        crossing = f.c_lvl > cfg_inter;
        if (phase_q == PH_IDLE) begin
            if (f.cmd_v) begin
                act_q    = f.cmd - 3'd1;
                queued_q = '0;
            end else if (queued_q[CMD_W]) begin
                act_q    = queued_q[CMD_W-1:0] - 3'd1;
                queued_q = '0;
            end
            if (f.link_lvl <= cfg_margin) begin
                ldrv_q = '0;
                rdrv_q = '0;
            end else begin
                case (act_q)
                    ACT_TURN_R, ACT_TURN_L: begin
                        if (crossing) begin
                            mode_q  = (act_q == ACT_TURN_R) ? MODE_RFWD : MODE_LFWD;
                            ldrv_q  = '0;
                            rdrv_q  = '0;
                            phase_q = PH_PAUSE;
                            hold_q  = cfg_tpause;
                        end else begin
                            balance_wheels(MODE_FWD, f.r_lvl, f.l_lvl);
                        end
                    end
                    ACT_FWD: balance_wheels(MODE_FWD, f.r_lvl, f.l_lvl);
                    ACT_BWD: balance_wheels(MODE_BWD, f.br_lvl, f.bl_lvl);
                    ACT_ROT: begin
                        mode_q  = MODE_LFWD;
                        ldrv_q  = sat_duty(cfg_rot);
                        rdrv_q  = sat_duty(cfg_rot);
                        phase_q = PH_PAUSE;
                        hold_q  = cfg_rpause;
                    end
                    default: begin
                        ldrv_q = '0;
                        rdrv_q = '0;
                    end
                endcase
            end
        end else begin
            // Hold a command for after the manoeuvre; the latest one wins
            if (f.cmd_v)
                queued_q = {1'b1, f.cmd};
            if (phase_q == PH_PAUSE) begin
                if (hold_q != 0) begin
                    hold_q = hold_q - 1'b1;
                end else begin
                    phase_q = PH_PIVOT;
                    if (act_q == ACT_TURN_R) begin
                        rdrv_q = sat_duty(cfg_base);
                        ldrv_q = '0;
                    end else if (act_q == ACT_TURN_L) begin
                        ldrv_q = sat_duty(cfg_base);
                        rdrv_q = '0;
                    end
                    finish_turn(f.r_lvl, f.l_lvl);
                end
            end else begin
                finish_turn(f.r_lvl, f.l_lvl);
            end
        end
        return '{ldrv_q, rdrv_q, mode_q, crossing};
    endfunction

    function automatic t_frame mk_frame(input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] l,
                                        input logic [LEVEL_W-1:0] c, input logic [LEVEL_W-1:0] br,
                                        input logic [LEVEL_W-1:0] bl,
                                        input logic [LEVEL_W-1:0] link,
                                        input logic cv, input logic [CMD_W-1:0] cb);
        return '{r, l, c, br, bl, link, cv, cb};
    endfunction

    // Random on-track frame; front codes agree or not, center above the crossing level or not
    function automatic t_frame rand_track(input bit aligned, input bit crossing);
        t_frame f;
        int     d;
        f       = {$urandom, $urandom};
        f.cmd_v = 1'b0;
        if (aligned) begin
            d = $urandom_range(0, int'(cfg_margin));
            d = $urandom_range(0, 1) ? int'(f.r_lvl) + d : int'(f.r_lvl) - d;
            f.l_lvl = (d < 0) ? '0 : ((d > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(d));
        end else begin
            for (int i = 0; i < 8 && level_gap(f.r_lvl, f.l_lvl) <= cfg_margin; i++)
                f.l_lvl = LEVEL_W'($urandom);
        end
        if ($urandom_range(0, 3) == 0)
            f.bl_lvl = f.br_lvl;
        if (crossing && cfg_inter < LEVEL_MAX)
            f.c_lvl = LEVEL_W'($urandom_range(int'(cfg_inter) + 1, LEVEL_MAX));
        else if (!crossing)
            f.c_lvl = LEVEL_W'($urandom_range(0, int'(cfg_inter)));
        if (cfg_margin < LEVEL_MAX)
            f.link_lvl = LEVEL_W'($urandom_range(int'(cfg_margin) + 1, LEVEL_MAX));
        return f;
    endfunction

    // Offer one frame, wait for it to be taken, then log its expected drive word
    task automatic send_frame(input t_frame f);
        t_drive want;
        if (!tx_steady && $urandom_range(0, 99) < 20) begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        frame_if.valid            <= 1'b1;
        frame_if.right_level      <= f.r_lvl;
        frame_if.left_level       <= f.l_lvl;
        frame_if.center_level     <= f.c_lvl;
        frame_if.back_right_level <= f.br_lvl;
        frame_if.back_left_level  <= f.bl_lvl;
        frame_if.link_level       <= f.link_lvl;
        frame_if.command_valid    <= f.cmd_v;
        frame_if.command_bits     <= f.cmd;
        do @(posedge i_clk); while (!frame_if.ready);
        want = predict_steering(f);
        expected_drive_q.push_back(want);
        frames_taken++;
    endtask

    // Drop valid and wait until every drive word has come back
    task automatic drain();
        frame_if.valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_BASE_DUTY:    cfg_base   = val[DUTY_W-1:0];
            CFG_ROTATE_DUTY:  cfg_rot    = val[DUTY_W-1:0];
            CFG_INTER_LEVEL:  cfg_inter  = val[LEVEL_W-1:0];
            CFG_MARGIN:       cfg_margin = val[LEVEL_W-1:0];
            CFG_TURN_PAUSE:   cfg_tpause = val[PAUSE_W-1:0];
            CFG_ROTATE_PAUSE: cfg_rpause = val[PAUSE_W-1:0];
            default: ;
        endcase
    endtask

    // Write all six registers; call only with the block idle
    task automatic load_regs(input t_regs v);
        write_reg(CFG_BASE_DUTY, v.base);
        write_reg(CFG_ROTATE_DUTY, v.rot);
        write_reg(CFG_INTER_LEVEL, v.inter);
        write_reg(CFG_MARGIN, v.margin);
        write_reg(CFG_TURN_PAUSE, v.tpause);
        write_reg(CFG_ROTATE_PAUSE, v.rpause);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed drives, turns and rotations with random content, plus noise
    task automatic run_random_traffic(input int n);
        int     stop_at;
        int     pick;
        int     guard;
        t_frame f;
        stop_at = frames_taken + n;
        while (frames_taken < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // straight run, forward or backward
                f       = rand_track($urandom_range(0, 2) == 0, 1'b0);
                f.cmd_v = 1'b1;
                f.cmd   = cmd_of($urandom_range(0, 1) ? ACT_FWD : ACT_BWD);
                send_frame(f);
                repeat ($urandom_range(3, 10)) begin
                    f = rand_track($urandom_range(0, 2) == 0, $urandom_range(0, 1));
                    if ($urandom_range(0, 19) == 0)
                        f.link_lvl = LEVEL_W'($urandom_range(0, int'(cfg_margin)));
                    send_frame(f);
                end
            end else if (pick < 62) begin
                if (pick < 50) begin
                    // turn: arm it, approach, reach the crossing
                    f       = rand_track(1'b0, 1'b0);
                    f.cmd_v = 1'b1;
                    f.cmd   = cmd_of($urandom_range(0, 1) ? ACT_TURN_R : ACT_TURN_L);
                    send_frame(f);
                    repeat ($urandom_range(0, 3))
                        send_frame(rand_track($urandom_range(0, 2) == 0, 1'b0));
                    send_frame(rand_track(1'b0, 1'b1));
                end else begin
                    f       = rand_track(1'b0, 1'b0);
                    f.cmd_v = 1'b1;
                    f.cmd   = cmd_of(ACT_ROT);
                    send_frame(f);
                end
                // pause and pivot until the codes agree, with stray commands
                guard = 0;
                while (phase_q != PH_IDLE && guard < 80) begin
                    f = rand_track($urandom_range(0, 3) == 0, $urandom_range(0, 1));
                    if ($urandom_range(0, 9) == 0) begin
                        f.cmd_v = 1'b1;
                        f.cmd   = CMD_W'($urandom);
                    end
                    send_frame(f);
                    guard++;
                end
            end else if (pick < 85) begin
                // on and off the track, with random commands
                repeat ($urandom_range(2, 8)) begin
                    f = rand_track($urandom_range(0, 2) == 0, $urandom_range(0, 1));
                    if ($urandom_range(0, 3) == 0)
                        f.link_lvl = LEVEL_W'($urandom_range(0, int'(cfg_margin)));
                    if ($urandom_range(0, 4) == 0) begin
                        f.cmd_v = 1'b1;
                        f.cmd   = CMD_W'($urandom);
                    end
                    send_frame(f);
                end
            end else begin
                f       = {$urandom, $urandom};
                f.cmd_v = $urandom_range(0, 9) < 3;
                send_frame(f);
            end
        end
    endtask

    task automatic test_directed_commands();
        // reset values: stopped, then forward at full codes
        send_frame(mk_frame(0, 0, 0, 0, 0, 0, 1'b0, '0));
        send_frame(mk_frame(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX,
                            1'b1, cmd_of(ACT_FWD)));
        drain();

        // duties above hundred, zero margin and no pauses
        load_regs('{127, 127, 0, 0, 0, 0});
        send_frame(mk_frame(LEVEL_MAX, 0, 0, 0, 0, 1, 1'b1, cmd_of(ACT_FWD)));
        send_frame(mk_frame(0, LEVEL_MAX, 1, 0, 0, LEVEL_MAX, 1'b0, '1));
        send_frame(mk_frame(500, 500, 0, 0, 0, 1, 1'b0, '0));
        send_frame(mk_frame(0, 0, 0, LEVEL_MAX, 300, 512, 1'b1, cmd_of(ACT_BWD)));
        // off track keeps the wheel mode
        send_frame(mk_frame(0, 0, 0, LEVEL_MAX, 300, 0, 1'b0, '0));
        send_frame(mk_frame(0, 0, 0, 0, LEVEL_MAX, 1, 1'b0, '0));
        // codes outside the action list and plain stop
        send_frame(mk_frame(200, 200, 0, 0, 0, 700, 1'b1, cmd_of(ACT_UNUSED_HI)));
        send_frame(mk_frame(200, 200, 0, 0, 0, 700, 1'b1, cmd_of(ACT_UNUSED_LO)));
        send_frame(mk_frame(200, 200, 0, 0, 0, 700, 1'b1, cmd_of(ACT_STOP)));
        // right turn: drive on until the crossing, pivot, hold a command
        send_frame(mk_frame(300, 200, 0, 0, 0, 800, 1'b1, cmd_of(ACT_TURN_R)));
        send_frame(mk_frame(300, 200, 5, 0, 0, 800, 1'b0, '0));
        send_frame(mk_frame(100, 200, 0, 400, 400, 0, 1'b1, cmd_of(ACT_BWD)));
        send_frame(mk_frame(150, 150, 0, 400, 400, 0, 1'b0, '0));
        send_frame(mk_frame(150, 150, 0, 400, 400, 900, 1'b0, '0));
        // left turn armed on the crossing frame itself; rotate held during the pivot
        send_frame(mk_frame(10, 20, 10, 0, 0, 900, 1'b1, cmd_of(ACT_TURN_L)));
        send_frame(mk_frame(10, 900, 0, 0, 0, 0, 1'b0, '0));
        send_frame(mk_frame(60, 60, 0, 0, 0, 0, 1'b1, cmd_of(ACT_ROT)));
        send_frame(mk_frame(60, 900, 0, 0, 0, 1, 1'b0, '0));
        send_frame(mk_frame(60, 900, 0, 0, 0, 1, 1'b0, '0));
        send_frame(mk_frame(70, 70, 0, 0, 0, 1, 1'b0, '0));
        drain();

        // upper extremes: every link code is off track, so nothing starts
        load_regs('{0, 0, LEVEL_MAX, LEVEL_MAX, HOLD_MAX, HOLD_MAX});
        send_frame(mk_frame(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX,
                            1'b1, cmd_of(ACT_ROT)));
        send_frame(mk_frame(LEVEL_MAX, 0, LEVEL_MAX, 0, LEVEL_MAX, LEVEL_MAX,
                            1'b1, cmd_of(ACT_FWD)));
        drain();

        // zero duties with a short blind rotation
        load_regs('{0, 0, 512, 0, 2, 1});
        send_frame(mk_frame(600, 2, 513, 0, 0, 300, 1'b1, cmd_of(ACT_FWD)));
        send_frame(mk_frame(600, 2, 512, 0, 0, 300, 1'b1, cmd_of(ACT_ROT)));
        send_frame(mk_frame(600, 2, 0, 0, 0, 300, 1'b0, '0));
        send_frame(mk_frame(40, 40, 0, 0, 0, 300, 1'b0, '0));
        drain();
    endtask

    // Stall the result side long enough for the block to stop taking frames
    task automatic test_output_backpressure();
        load_regs('{60, 45, 310, 31, 3, 2});
        rx_hold_cycles = 400;
        run_random_traffic(12);
        drain();
    endtask

    task automatic test_random_driving();
        t_regs regs;
        for (int ph = 0; ph < 4; ph++) begin
            regs.base   = (ph == 0) ? 127 : ((ph == 3) ? 100 : $urandom_range(0, 100));
            regs.rot    = (ph == 3) ? 127 : $urandom_range(0, 100);
            regs.inter  = $urandom_range(100, 900);
            regs.margin = (ph == 3) ? 0 : $urandom_range(1, 60);
            regs.tpause = (ph == 2) ? 40 : $urandom_range(0, 6);
            regs.rpause = (ph == 2) ? 25 : $urandom_range(0, 6);
            tx_steady   = (ph == 1);
            rx_steady   = (ph == 1);
            load_regs(regs);
            run_random_traffic(400);
            drain();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Compare one taken drive word with the oldest expectation
    task automatic check_result();
        t_drive want;
        if (expected_drive_q.size() == 0) begin
            $display("%0t: unexpected result left=%0d right=%0d mode=%0d cross=%0d", $time,
                     result_if.left_duty, result_if.right_duty, result_if.wheel_mode,
                     result_if.at_intersection);
            mismatch_cnt++;
        end else begin
            want = expected_drive_q.pop_front();
            if (result_if.left_duty !== want.l_duty) begin
                $display("%0t: left_duty expected %0d actual %0d", $time, want.l_duty,
                         result_if.left_duty);
                mismatch_cnt++;
            end
            if (result_if.right_duty !== want.r_duty) begin
                $display("%0t: right_duty expected %0d actual %0d", $time, want.r_duty,
                         result_if.right_duty);
                mismatch_cnt++;
            end
            if (result_if.wheel_mode !== want.mode) begin
                $display("%0t: wheel_mode expected %0d actual %0d", $time, want.mode,
                         result_if.wheel_mode);
                mismatch_cnt++;
            end
            if (result_if.at_intersection !== want.crossing) begin
                $display("%0t: at_intersection expected %0d actual %0d", $time, want.crossing,
                         result_if.at_intersection);
                mismatch_cnt++;
            end
        end
    endtask

    // Result side: check each taken word, then pick the next ready
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready)
                check_result();
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                result_if.ready <= 1'b0;
            end else if (rx_steady) begin
                result_if.ready <= 1'b1;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Watchdog: end the run after too long without a word on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n                   <= 1'b0;
        i_cfg_we                  <= 1'b0;
        i_cfg_idx                 <= CFG_BASE_DUTY;
        i_cfg_data                <= '0;
        frame_if.valid            <= 1'b0;
        frame_if.right_level      <= '0;
        frame_if.left_level       <= '0;
        frame_if.center_level     <= '0;
        frame_if.back_right_level <= '0;
        frame_if.back_left_level  <= '0;
        frame_if.link_level       <= '0;
        frame_if.command_valid    <= 1'b0;
        frame_if.command_bits     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_commands();
        test_output_backpressure();
        test_random_driving();

        // let any stray result show up
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_drive_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
